// ===== src/co2_response_frame_checker_defines.svh =====
// assertion helpers for the response frame checker
`ifndef CO2_RESPONSE_FRAME_CHECKER_DEFINES_SVH
`define CO2_RESPONSE_FRAME_CHECKER_DEFINES_SVH

`ifndef SYNTH
`define CO2FC_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("co2fc assertion failed");
`define CO2FC_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("co2fc assertion failed");
`define CO2FC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("co2fc assertion failed");
`else
`define CO2FC_ASSERT(label, clk, rst, prop)
`define CO2FC_ASSERT_IMP(label, clk, rst, ante, cons)
`define CO2FC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== src/co2fc_pkg.sv =====
package co2fc_pkg;

   localparam int FRAME_BYTES = 9;
   localparam int POS_W       = 4;

   localparam logic [POS_W-1:0] POS_FIRST   = '0;
   localparam logic [POS_W-1:0] POS_HDR1    = POS_W'(1);
   localparam logic [POS_W-1:0] POS_PPM_HI  = POS_W'(2);
   localparam logic [POS_W-1:0] POS_PPM_LO  = POS_W'(3);
   localparam logic [POS_W-1:0] POS_STATUS  = POS_W'(5);
   localparam logic [POS_W-1:0] POS_LAST    = POS_W'(FRAME_BYTES - 1);

   localparam logic [7:0] HDR0_BYTE = 8'hFF;
   localparam logic [7:0] HDR1_BYTE = 8'h86;
   localparam logic [7:0] CHK_BASE  = 8'hFF;
   localparam logic [7:0] CHK_ONE   = 8'h01;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] REG_MINIMAL_BELOW = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_WARNING_ABOVE = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] REG_DANGER_ABOVE  = CSR_IDX_W'(2);

   localparam logic [15:0] MINIMAL_BELOW_RST = 16'd600;
   localparam logic [15:0] WARNING_ABOVE_RST = 16'd1000;
   localparam logic [15:0] DANGER_ABOVE_RST  = 16'd2500;

   localparam logic [1:0] BAND_MINIMAL = 2'd0;
   localparam logic [1:0] BAND_NORMAL  = 2'd1;
   localparam logic [1:0] BAND_WARNING = 2'd2;
   localparam logic [1:0] BAND_DANGER  = 2'd3;

   typedef struct packed {
      logic        good;
      logic [15:0] ppm;
      logic [7:0]  status;
   } frame_result_type;

endpackage

// ===== src/co2fc_tracker.sv =====
`include "co2_response_frame_checker_defines.svh"

module co2fc_tracker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         beat_accept,
   input  logic [7:0]                   rx_byte,
   input  logic                         frame_start,
   output logic                         last_pending,
   output logic                         frame_done,
   output co2fc_pkg::frame_result_type  result
);

   logic [co2fc_pkg::POS_W-1:0] pos_ff, pos_in, pos_cur;
   logic [7:0]  sum_ff, sum_in;
   logic        hdr_ff, hdr_in;
   logic [15:0] cap_ppm_ff, cap_ppm_in;
   logic [7:0]  cap_status_ff, cap_status_in;
   logic [15:0] last_good_ff, last_good_in;
   logic [7:0]  checksum;
   logic        good;

   assign pos_cur      = frame_start ? co2fc_pkg::POS_FIRST : pos_ff;
   assign last_pending = (pos_ff == co2fc_pkg::POS_LAST);
   // two's complement of the running sum
   assign checksum     = co2fc_pkg::CHK_BASE - sum_ff + co2fc_pkg::CHK_ONE;
   assign good         = hdr_ff && (rx_byte == checksum);
   assign frame_done   = beat_accept && (pos_cur == co2fc_pkg::POS_LAST);

   always_comb begin
      pos_in        = pos_ff;
      sum_in        = sum_ff;
      hdr_in        = hdr_ff;
      cap_ppm_in    = cap_ppm_ff;
      cap_status_in = cap_status_ff;
      last_good_in  = last_good_ff;
      if (beat_accept) begin
         if (pos_cur == co2fc_pkg::POS_FIRST) begin
            hdr_in = (rx_byte == co2fc_pkg::HDR0_BYTE);
            sum_in = '0;
            pos_in = pos_cur + co2fc_pkg::POS_W'(1);
         end else if (pos_cur != co2fc_pkg::POS_LAST) begin
            sum_in = sum_ff + rx_byte;
            if (pos_cur == co2fc_pkg::POS_HDR1) begin
               hdr_in = hdr_ff && (rx_byte == co2fc_pkg::HDR1_BYTE);
            end
            if (pos_cur == co2fc_pkg::POS_PPM_HI) begin
               cap_ppm_in = {rx_byte, cap_ppm_ff[7:0]};
            end
            if (pos_cur == co2fc_pkg::POS_PPM_LO) begin
               cap_ppm_in = {cap_ppm_ff[15:8], rx_byte};
            end
            if (pos_cur == co2fc_pkg::POS_STATUS) begin
               cap_status_in = rx_byte;
            end
            pos_in = pos_cur + co2fc_pkg::POS_W'(1);
         end else begin
            if (good) begin
               last_good_in = cap_ppm_ff;
            end
            pos_in = co2fc_pkg::POS_FIRST;
         end
      end
   end

   always_comb begin
      result.good   = good;
      result.ppm    = good ? cap_ppm_ff : last_good_ff;
      result.status = good ? cap_status_ff : 8'h00;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff        <= co2fc_pkg::POS_FIRST;
         sum_ff        <= '0;
         hdr_ff        <= 1'b0;
         cap_ppm_ff    <= '0;
         cap_status_ff <= '0;
         last_good_ff  <= '0;
      end else begin
         pos_ff        <= pos_in;
         sum_ff        <= sum_in;
         hdr_ff        <= hdr_in;
         cap_ppm_ff    <= cap_ppm_in;
         cap_status_ff <= cap_status_in;
         last_good_ff  <= last_good_in;
      end
   end

   `CO2FC_ASSERT(a_pos_range, clock, reset, pos_ff <= co2fc_pkg::POS_LAST)
   `CO2FC_ASSERT_IMP(a_done_at_last, clock, reset, frame_done, last_pending && !frame_start)
   `CO2FC_ASSERT_NEXT(a_wrap_after_done, clock, reset, frame_done, pos_ff == co2fc_pkg::POS_FIRST)

endmodule

// ===== src/co2fc_band_out.sv =====
module co2fc_band_out (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_write,
   input  logic [co2fc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [co2fc_pkg::CSR_DATA_W-1:0]      csr_data,
   input  logic                                  frame_done,
   input  co2fc_pkg::frame_result_type           result,
   input  logic                                  rsp_stall,
   output logic                                  rsp_valid,
   output logic                                  rsp_frame_good,
   output logic [15:0]                           rsp_ppm_value,
   output logic [7:0]                            rsp_sensor_status,
   output logic [1:0]                            rsp_level_band
);

   logic [15:0] min_below_ff, min_below_in;
   logic [15:0] warn_above_ff, warn_above_in;
   logic [15:0] danger_above_ff, danger_above_in;
   logic        valid_ff, valid_in;
   logic        good_ff;
   logic [15:0] ppm_ff;
   logic [7:0]  status_ff;
   logic [1:0]  band_ff, band;

   always_comb begin
      min_below_in    = min_below_ff;
      warn_above_in   = warn_above_ff;
      danger_above_in = danger_above_ff;
      if (csr_write) begin
         unique case (csr_index)
            co2fc_pkg::REG_MINIMAL_BELOW: min_below_in    = csr_data;
            co2fc_pkg::REG_WARNING_ABOVE: warn_above_in   = csr_data;
            co2fc_pkg::REG_DANGER_ABOVE:  danger_above_in = csr_data;
            default: ;
         endcase
      end
   end

   // fixed priority, thresholds need not be ordered
   always_comb begin
      if (result.ppm < min_below_ff) begin
         band = co2fc_pkg::BAND_MINIMAL;
      end else if (result.ppm > danger_above_ff) begin
         band = co2fc_pkg::BAND_DANGER;
      end else if (result.ppm > warn_above_ff) begin
         band = co2fc_pkg::BAND_WARNING;
      end else begin
         band = co2fc_pkg::BAND_NORMAL;
      end
   end

   assign valid_in = frame_done || (valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         min_below_ff    <= co2fc_pkg::MINIMAL_BELOW_RST;
         warn_above_ff   <= co2fc_pkg::WARNING_ABOVE_RST;
         danger_above_ff <= co2fc_pkg::DANGER_ABOVE_RST;
         valid_ff        <= 1'b0;
      end else begin
         min_below_ff    <= min_below_in;
         warn_above_ff   <= warn_above_in;
         danger_above_ff <= danger_above_in;
         valid_ff        <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (frame_done) begin
         good_ff   <= result.good;
         ppm_ff    <= result.ppm;
         status_ff <= result.status;
         band_ff   <= band;
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_frame_good    = good_ff;
   assign rsp_ppm_value     = ppm_ff;
   assign rsp_sensor_status = status_ff;
   assign rsp_level_band    = band_ff;

endmodule

// ===== src/co2_response_frame_checker.sv =====
// the result beat is registered and shows in the cycle after the ninth byte is taken
// throughput: one byte per cycle unless stalled; a frame gives at most one result every nine bytes
// input stalls only when the last byte of a frame is due and the held result is stalled
// reset: synchronous, active high; clears the frame position, sums and kept concentration,
// and loads the thresholds with 600, 1000 and 2500
module co2_response_frame_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [7:0]                        req_rx_byte,
   input  logic                              req_frame_start,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_frame_good,
   output logic [15:0]                       rsp_ppm_value,
   output logic [7:0]                        rsp_sensor_status,
   output logic [1:0]                        rsp_level_band,
   input  logic                              csr_write,
   input  logic [co2fc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [co2fc_pkg::CSR_DATA_W-1:0]  csr_data
);

   logic                        beat_accept;
   logic                        last_pending;
   logic                        frame_done;
   co2fc_pkg::frame_result_type result;

   // hold off the closing byte while the result register is still occupied
   assign req_stall   = last_pending && rsp_valid && rsp_stall;
   assign beat_accept = req_valid && !req_stall;

   co2fc_tracker u_tracker (
      .clock        (clock),
      .reset        (reset),
      .beat_accept  (beat_accept),
      .rx_byte      (req_rx_byte),
      .frame_start  (req_frame_start),
      .last_pending (last_pending),
      .frame_done   (frame_done),
      .result       (result)
   );

   co2fc_band_out u_band_out (
      .clock             (clock),
      .reset             (reset),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .frame_done        (frame_done),
      .result            (result),
      .rsp_stall         (rsp_stall),
      .rsp_valid         (rsp_valid),
      .rsp_frame_good    (rsp_frame_good),
      .rsp_ppm_value     (rsp_ppm_value),
      .rsp_sensor_status (rsp_sensor_status),
      .rsp_level_band    (rsp_level_band)
   );

endmodule

// ===== bench/co2_response_frame_checker_test.sv =====
module co2_response_frame_checker_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [co2fc_pkg::CSR_IDX_W-1:0] REG_SPARE = co2fc_pkg::CSR_IDX_W'(3);
   localparam int RANDOM_BYTES = 1830;
   localparam int PHASES       = 8;
   localparam int QUIET_LIMIT  = 4000;
   localparam int DRAIN_CYCLES = 4;
   localparam int NO_SPOIL     = -1;

   typedef struct packed {
      logic        good;
      logic [15:0] ppm;
      logic [7:0]  status;
      logic [1:0]  band;
   } frame_report_type;

   // frame decoder mirror: holds the thresholds, the frame state and the reports still due
   class frame_checker_model;
      logic [15:0]                 minimal_below, warning_above, danger_above;
      logic [co2fc_pkg::POS_W-1:0] position;
      logic [7:0]                  checksum_acc;
      logic                        header_ok;
      logic [15:0]                 ppm_capture, ppm_kept;
      logic [7:0]                  status_capture;
      frame_report_type            due_reports[$];
      int                          errors, good_frames, bad_frames;

      function new();
         minimal_below  = co2fc_pkg::MINIMAL_BELOW_RST;
         warning_above  = co2fc_pkg::WARNING_ABOVE_RST;
         danger_above   = co2fc_pkg::DANGER_ABOVE_RST;
         position       = co2fc_pkg::POS_FIRST;
         checksum_acc   = '0;
         header_ok      = 1'b0;
         ppm_capture    = '0;
         ppm_kept       = '0;
         status_capture = '0;
         errors         = 0;
         good_frames    = 0;
         bad_frames     = 0;
      endfunction

      function void set_threshold(logic [co2fc_pkg::CSR_IDX_W-1:0] index,
                                  logic [15:0] value);
         case (index)
            co2fc_pkg::REG_MINIMAL_BELOW: minimal_below = value;
            co2fc_pkg::REG_WARNING_ABOVE: warning_above = value;
            co2fc_pkg::REG_DANGER_ABOVE:  danger_above = value;
            default: ;
         endcase
      endfunction

      // fixed priority, so out-of-order thresholds still give one answer
      function logic [1:0] band_for(logic [15:0] ppm);
         if (ppm < minimal_below) return co2fc_pkg::BAND_MINIMAL;
         else if (ppm > danger_above) return co2fc_pkg::BAND_DANGER;
         else if (ppm > warning_above) return co2fc_pkg::BAND_WARNING;
         else return co2fc_pkg::BAND_NORMAL;
      endfunction

      function void take_byte(logic [7:0] rx, logic start);
         frame_report_type report;
         logic [7:0]       want_sum;
         if (start) position = co2fc_pkg::POS_FIRST;
         if (position == co2fc_pkg::POS_FIRST) begin
            header_ok    = (rx == co2fc_pkg::HDR0_BYTE);
            checksum_acc = '0;
            position     = position + 1'b1;
         end else if (position != co2fc_pkg::POS_LAST) begin
            checksum_acc = checksum_acc + rx;
            if (position == co2fc_pkg::POS_HDR1)
               header_ok = header_ok && (rx == co2fc_pkg::HDR1_BYTE);
            if (position == co2fc_pkg::POS_PPM_HI) ppm_capture[15:8] = rx;
            if (position == co2fc_pkg::POS_PPM_LO) ppm_capture[7:0] = rx;
            if (position == co2fc_pkg::POS_STATUS) status_capture = rx;
            position = position + 1'b1;
         end else begin
            want_sum    = co2fc_pkg::CHK_BASE - checksum_acc + co2fc_pkg::CHK_ONE;
            report.good = header_ok && (rx == want_sum);
            if (report.good) begin
               ppm_kept = ppm_capture;
               good_frames++;
            end else begin
               bad_frames++;
            end
            report.ppm    = ppm_kept;
            report.status = report.good ? status_capture : 8'h00;
            report.band   = band_for(ppm_kept);
            due_reports.push_back(report);
            position = co2fc_pkg::POS_FIRST;
         end
      endfunction

      function void compare_result(logic good, logic [15:0] ppm, logic [7:0] status,
                                   logic [1:0] band);
         frame_report_type want;
         if (due_reports.size() == 0) begin
            errors++;
            $error("frame result beat with no frame pending");
            return;
         end
         want = due_reports.pop_front();
         if (good !== want.good) begin
            errors++;
            $error("frame_good: expected %0d, got %0d", want.good, good);
         end
         if (ppm !== want.ppm) begin
            errors++;
            $error("ppm_value: expected %0d, got %0d", want.ppm, ppm);
         end
         if (status !== want.status) begin
            errors++;
            $error("sensor_status: expected 0x%02h, got 0x%02h", want.status, status);
         end
         if (band !== want.band) begin
            errors++;
            $error("level_band: expected %0d, got %0d", want.band, band);
         end
      endfunction
   endclass

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_valid = 1'b0;
   logic                             req_stall;
   logic [7:0]                       req_rx_byte = '0;
   logic                             req_frame_start = 1'b0;
   logic                             rsp_valid;
   logic                             rsp_stall = 1'b0;
   logic                             rsp_frame_good;
   logic [15:0]                      rsp_ppm_value;
   logic [7:0]                       rsp_sensor_status;
   logic [1:0]                       rsp_level_band;
   logic                             csr_write = 1'b0;
   logic [co2fc_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [co2fc_pkg::CSR_DATA_W-1:0] csr_data = '0;

   frame_checker_model model = new();
   int idle_pct = 0;
   int stall_pct = 0;
   int bytes_sent = 0;
   int settings_done = 0;
   int quiet_cycles = 0;
   bit moved;

   co2_response_frame_checker dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_rx_byte       (req_rx_byte),
      .req_frame_start   (req_frame_start),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_frame_good    (rsp_frame_good),
      .rsp_ppm_value     (rsp_ppm_value),
      .rsp_sensor_status (rsp_sensor_status),
      .rsp_level_band    (rsp_level_band),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   always #4 clock = ~clock;

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // beat monitor and watchdog
   always @(posedge clock) begin
      if (!reset) begin
         moved = 1'b0;
         if (csr_write) begin
            model.set_threshold(csr_index, csr_data);
            moved = 1'b1;
         end
         if (req_valid && !req_stall) begin
            model.take_byte(req_rx_byte, req_frame_start);
            moved = 1'b1;
         end
         if (rsp_valid && !rsp_stall) begin
            model.compare_result(rsp_frame_good, rsp_ppm_value, rsp_sensor_status,
                                 rsp_level_band);
            moved = 1'b1;
         end
         quiet_cycles = moved ? 0 : quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   task automatic send_byte(input logic [7:0] rx, input logic start);
      @(negedge clock);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_rx_byte     <= rx;
      req_frame_start <= start;
      do @(posedge clock); while (req_stall);
      bytes_sent++;
   endtask

   // build a frame with a correct checksum, optionally spoil one byte, send a prefix of it
   task automatic send_frame(input logic [15:0] ppm, input logic [7:0] status,
                             input logic first_start, input int spoil_at, input int length);
      logic [7:0] frame [co2fc_pkg::FRAME_BYTES];
      logic [7:0] sum;
      frame[0] = co2fc_pkg::HDR0_BYTE;
      frame[1] = co2fc_pkg::HDR1_BYTE;
      frame[2] = ppm[15:8];
      frame[3] = ppm[7:0];
      frame[4] = 8'($urandom);
      frame[5] = status;
      frame[6] = 8'($urandom);
      frame[7] = 8'($urandom);
      if (spoil_at >= 0 && spoil_at < co2fc_pkg::FRAME_BYTES - 1)
         frame[spoil_at] = frame[spoil_at] ^ 8'($urandom_range(1, 255));
      sum = '0;
      for (int i = 1; i < co2fc_pkg::FRAME_BYTES - 1; i++) sum = sum + frame[i];
      frame[co2fc_pkg::FRAME_BYTES-1] = 8'h00 - sum;
      if (spoil_at == co2fc_pkg::FRAME_BYTES - 1)
         frame[spoil_at] = frame[spoil_at] ^ 8'($urandom_range(1, 255));
      for (int i = 0; i < length; i++) send_byte(frame[i], (i == 0) ? first_start : 1'b0);
   endtask

   // hold the sender off until every frame report has come back
   task automatic pause_sender();
      @(negedge clock);
      req_valid <= 1'b0;
      while (model.due_reports.size() != 0) @(negedge clock);
   endtask

   task automatic write_thresholds(input logic [co2fc_pkg::CSR_DATA_W-1:0] minimal,
                                   input logic [co2fc_pkg::CSR_DATA_W-1:0] warning,
                                   input logic [co2fc_pkg::CSR_DATA_W-1:0] danger);
      pause_sender();
      repeat (DRAIN_CYCLES) @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= co2fc_pkg::REG_MINIMAL_BELOW;
      csr_data  <= minimal;
      @(negedge clock);
      csr_index <= co2fc_pkg::REG_WARNING_ABOVE;
      csr_data  <= warning;
      @(negedge clock);
      csr_index <= co2fc_pkg::REG_DANGER_ABOVE;
      csr_data  <= danger;
      @(negedge clock);
      // index past the last register must be ignored
      csr_index <= REG_SPARE;
      csr_data  <= co2fc_pkg::CSR_DATA_W'($urandom);
      @(negedge clock);
      csr_write <= 1'b0;
      settings_done++;
   endtask

   // concentrations near the current thresholds, or anywhere
   function automatic logic [15:0] pick_ppm();
      logic [15:0] mark;
      case ($urandom_range(3))
         0: return 16'($urandom);
         1: mark = model.minimal_below;
         2: mark = model.warning_above;
         default: mark = model.danger_above;
      endcase
      return mark + 16'($urandom_range(2)) - 16'd1;
   endfunction

   task automatic random_traffic(input int budget);
      int   stop_at;
      int   pick;
      logic aligned;
      stop_at = bytes_sent + budget;
      aligned = 1'b0;
      while (bytes_sent < stop_at) begin
         pick = $urandom_range(99);
         if (pick < 55) begin
            send_frame(pick_ppm(), 8'($urandom), 1'b1, NO_SPOIL, co2fc_pkg::FRAME_BYTES);
            aligned = 1'b1;
         end else if (pick < 65) begin
            // counter wraps after a whole frame, so the start flag is sent only when not aligned
            send_frame(pick_ppm(), 8'($urandom), !aligned, NO_SPOIL,
                       co2fc_pkg::FRAME_BYTES);
            aligned = 1'b1;
         end else if (pick < 73) begin
            send_frame(pick_ppm(), 8'($urandom), 1'b1, int'(co2fc_pkg::POS_FIRST),
                       co2fc_pkg::FRAME_BYTES);
            aligned = 1'b1;
         end else if (pick < 79) begin
            send_frame(pick_ppm(), 8'($urandom), 1'b1, int'(co2fc_pkg::POS_HDR1),
                       co2fc_pkg::FRAME_BYTES);
            aligned = 1'b1;
         end else if (pick < 87) begin
            send_frame(pick_ppm(), 8'($urandom), 1'b1, int'(co2fc_pkg::POS_LAST),
                       co2fc_pkg::FRAME_BYTES);
            aligned = 1'b1;
         end else if (pick < 93) begin
            send_frame(pick_ppm(), 8'($urandom), 1'b1, NO_SPOIL,
                       $urandom_range(1, co2fc_pkg::FRAME_BYTES - 1));
            aligned = 1'b0;
         end else if (pick < 97) begin
            repeat ($urandom_range(1, 5)) send_byte(8'($urandom), $urandom_range(3) == 0);
            aligned = 1'b0;
         end else begin
            pause_sender();
         end
      end
   endtask

   initial begin
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      // first byte after reset is byte 0 even without the start flag
      send_frame(16'hFFFF, 8'hFF, 1'b0, NO_SPOIL, co2fc_pkg::FRAME_BYTES);
      // start flag inside a frame drops the partial frame
      send_frame(16'h1234, 8'h55, 1'b1, NO_SPOIL, 3);
      // bad checksum keeps the earlier concentration and zeroes the status
      send_frame(16'h0000, 8'h00, 1'b1, int'(co2fc_pkg::POS_LAST), co2fc_pkg::FRAME_BYTES);

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: ;
            1: write_thresholds(16'h0000, 16'h0000, 16'h0000);
            2: write_thresholds(16'hFFFF, 16'hFFFF, 16'hFFFF);
            3: write_thresholds(16'd3000, 16'd2000, 16'd100);
            4: write_thresholds(16'h0000, 16'hFFFF, 16'hFFFF);
            default: write_thresholds(16'($urandom), 16'($urandom), 16'($urandom));
         endcase
         case (phase % 4)
            0: begin
               idle_pct  = 0;
               stall_pct = 0;
            end
            1: begin
               idle_pct  = 84;
               stall_pct = 0;
            end
            2: begin
               idle_pct  = 0;
               stall_pct = 84;
            end
            default: begin
               idle_pct  = 36;
               stall_pct = 36;
            end
         endcase
         random_traffic(RANDOM_BYTES / PHASES);
      end

      pause_sender();
      repeat (DRAIN_CYCLES) @(negedge clock);
      $display("run covered %0d bytes giving %0d good and %0d bad frame reports",
               bytes_sent, model.good_frames, model.bad_frames);
      $display("over %0d rewritten threshold sets plus the reset set, under four idling mixes",
               settings_done);
      if (model.errors == 0 && model.due_reports.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
